@@ hw/rtl/ipm_pkg.sv @@
// Shared types and constants for the input plausibility monitor.
// Holds the field widths, the register indexes and the fault bit positions.
// Depends on nothing.
package ipm_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int LIMIT_W   = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MASK_W    = 7;

    // Number of individually watched switches (start, light, horn, left, right)
    localparam int NUM_SWITCHES = 5;

    // Packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STUCK_HOLD   = 2'd0,
        REG_DUAL_HOLD    = 2'd1,
        REG_PULSE_LIMIT  = 2'd2,
        REG_OFF_WINDOW   = 2'd3
    } cfg_reg_t;

    // Fault mask bit positions
    localparam int FAULT_START = 0;
    localparam int FAULT_LEFT  = 3;
    localparam int FAULT_RIGHT = 4;
    localparam int FAULT_DUAL  = 5;
    localparam int FAULT_SPEED = 6;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0]  STUCK_HOLD_RESET  = 32'd10000;
    localparam logic [TIME_W-1:0]  DUAL_HOLD_RESET   = 32'd3000;
    localparam logic [LIMIT_W-1:0] PULSE_LIMIT_RESET = 16'd5;
    localparam logic [TIME_W-1:0]  OFF_WINDOW_RESET  = 32'd2000;

    // One check item as held in the input register
    typedef struct packed {
        logic                    starter_engaged;
        logic [COUNT_W-1:0]      speed_pulses;
        logic                    ignition_on;
        logic                    hazard_on;
        logic [NUM_SWITCHES-1:0] switches;
        logic [TIME_W-1:0]       now_ms;
    } check_item_t;

    // One result item
    typedef struct packed {
        logic              starter_cut;
        logic              implausible;
        logic              restored;
        logic [MASK_W-1:0] new_faults;
        logic [MASK_W-1:0] fault_mask;
    } result_item_t;

endpackage

@@ hw/rtl/input_plausibility_monitor.sv @@
// Input plausibility monitor: stuck switch, dual turn and ignition-off speed checks.
// An accepted item is held in the input register, and its result then in the result register.
// Throughput: one item per cycle while results are taken; the input and result registers
// each hold one item, so one more item is taken while a result waits downstream.
// Reset clears all tracking state and loads the default thresholds.
// Depends on ipm_pkg, ipm_hold_timer and ipm_speed_window.
module input_plausibility_monitor
    import ipm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Check items in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], start_pressed[32], light_pressed[33], horn_pressed[34],
    // left_turn_pressed[35], right_turn_pressed[36], hazard_on[37],
    // ignition_on[38], speed_pulses[70:39], starter_engaged[71]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result items out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // fault_mask[6:0], new_faults[13:7], restored[14], implausible[15],
    // starter_cut[16], zero padding[23:17]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int ITEM_W   = $bits(check_item_t);
    localparam int RESULT_W = $bits(result_item_t);

    logic [TIME_W-1:0]  stuck_hold_reg;
    logic [TIME_W-1:0]  dual_hold_reg;
    logic [LIMIT_W-1:0] pulse_limit_reg;
    logic [TIME_W-1:0]  off_window_reg;

    logic               in_valid_reg;
    check_item_t        in_item_reg;
    logic               out_valid_reg;
    result_item_t       out_item_reg;
    result_item_t       result_next;
    logic [MASK_W-1:0]  prev_mask_reg;
    logic [MASK_W-1:0]  mask;
    logic [NUM_SWITCHES-1:0] stuck;
    logic               dual_active;
    logic               dual_fault;
    logic               speed_fault;
    logic               advance;
    logic               process;

    // The result register moves on when empty or taken; the input register
    // refills whenever its item moves on.
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_item_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuck_hold_reg  <= STUCK_HOLD_RESET;
            dual_hold_reg   <= DUAL_HOLD_RESET;
            pulse_limit_reg <= PULSE_LIMIT_RESET;
            off_window_reg  <= OFF_WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STUCK_HOLD:  stuck_hold_reg  <= cfg_wdata;
                REG_DUAL_HOLD:   dual_hold_reg   <= cfg_wdata;
                REG_PULSE_LIMIT: pulse_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_OFF_WINDOW:  off_window_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= check_item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    // One hold timer per switch
    for (genvar i = 0; i < NUM_SWITCHES; i++)
    begin : g_switch
        ipm_hold_timer u_timer (
            .clk    (clk),
            .rst_n  (rst_n),
            .update (process),
            .active (in_item_reg.switches[i]),
            .now_ms (in_item_reg.now_ms),
            .limit  (stuck_hold_reg),
            .fault  (stuck[i])
        );
    end

    // Both turn switches held while the hazard lights are off
    assign dual_active = in_item_reg.switches[FAULT_LEFT]
                      && in_item_reg.switches[FAULT_RIGHT]
                      && !in_item_reg.hazard_on;

    ipm_hold_timer u_dual_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (process),
        .active (dual_active),
        .now_ms (in_item_reg.now_ms),
        .limit  (dual_hold_reg),
        .fault  (dual_fault)
    );

    ipm_speed_window u_speed (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (process),
        .now_ms       (in_item_reg.now_ms),
        .ignition_on  (in_item_reg.ignition_on),
        .speed_pulses (in_item_reg.speed_pulses),
        .pulse_limit  (pulse_limit_reg),
        .window_ms    (off_window_reg),
        .fault        (speed_fault)
    );

    // Fault mask and derived flags
    always_comb
    begin
        mask = '0;
        mask[NUM_SWITCHES-1:0] = stuck;
        mask[FAULT_DUAL]       = dual_fault;
        mask[FAULT_SPEED]      = speed_fault;
        result_next.fault_mask  = mask;
        result_next.new_faults  = mask & ~prev_mask_reg;
        result_next.restored    = (prev_mask_reg != '0) && (mask == '0);
        result_next.implausible = (mask != '0);
        result_next.starter_cut = mask[FAULT_START] && in_item_reg.starter_engaged;
    end

    // Result register and previous mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_mask_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                prev_mask_reg <= mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_item_reg <= result_item_t'(result_next[RESULT_W-1:0]);
        end
    end

endmodule

@@ hw/rtl/ipm_hold_timer.sv @@
// Hold timer for one active-level condition of the plausibility monitor.
// Tracks when the condition became active and flags it once held too long.
// Depends on ipm_pkg.
module ipm_hold_timer
    import ipm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  logic              active,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] limit,
    output logic              fault
);

    logic [TIME_W-1:0] since_reg;
    logic [TIME_W-1:0] since_next;
    logic              running_reg;
    logic              running_next;
    logic [TIME_W-1:0] held;

    // A condition that starts now has been held for zero time.
    always_comb
    begin
        held  = running_reg ? (now_ms - since_reg) : '0;
        fault = active && (held >= limit);
        if (!active)
        begin
            running_next = 1'b0;
            since_next   = '0;
        end
        else if (!running_reg)
        begin
            running_next = 1'b1;
            since_next   = now_ms;
        end
        else
        begin
            running_next = 1'b1;
            since_next   = since_reg;
        end
    end

    // Timer state advances once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg   <= '0;
            running_reg <= 1'b0;
        end
        else if (update)
        begin
            since_reg   <= since_next;
            running_reg <= running_next;
        end
    end

endmodule

@@ hw/rtl/ipm_speed_window.sv @@
// Speed pulse window of the plausibility monitor.
// Counts speed pulses seen while the ignition is off inside a time window.
// Depends on ipm_pkg.
module ipm_speed_window
    import ipm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               ignition_on,
    input  logic [COUNT_W-1:0] speed_pulses,
    input  logic [LIMIT_W-1:0] pulse_limit,
    input  logic [TIME_W-1:0]  window_ms,
    output logic               fault
);

    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  start_next;
    logic               open_reg;
    logic               open_next;
    logic [COUNT_W-1:0] base_reg;
    logic [COUNT_W-1:0] base_next;
    logic [COUNT_W-1:0] prev_count_reg;
    logic               open_now;
    logic [TIME_W-1:0]  start_now;
    logic [COUNT_W-1:0] base_now;
    logic [COUNT_W-1:0] delta;
    logic [TIME_W-1:0]  elapsed;

    // A change of the pulse count with the ignition off opens a window
    // based on the previous count.
    always_comb
    begin
        open_now  = open_reg || (speed_pulses != prev_count_reg);
        start_now = open_reg ? start_reg : now_ms;
        base_now  = open_reg ? base_reg : prev_count_reg;
        delta     = speed_pulses - base_now;
        elapsed   = now_ms - start_now;
        fault     = 1'b0;
        open_next  = open_reg;
        start_next = start_reg;
        base_next  = base_reg;
        if (ignition_on)
        begin
            open_next  = 1'b0;
            start_next = '0;
            base_next  = speed_pulses;
        end
        else if (open_now)
        begin
            open_next  = 1'b1;
            start_next = start_now;
            base_next  = base_now;
            if ((delta >= COUNT_W'(pulse_limit)) && (elapsed <= window_ms))
            begin
                fault = 1'b1;
            end
            else if (elapsed > window_ms)
            begin
                open_next  = 1'b0;
                start_next = '0;
                base_next  = speed_pulses;
            end
        end
    end

    // Window state advances once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= '0;
            open_reg       <= 1'b0;
            base_reg       <= '0;
            prev_count_reg <= '0;
        end
        else if (update)
        begin
            start_reg      <= start_next;
            open_reg       <= open_next;
            base_reg       <= base_next;
            prev_count_reg <= speed_pulses;
        end
    end

endmodule
